// File: rtl/rts_pkg.sv
`timescale 1ns / 1ps

package rts_pkg;

    localparam int SAMPLES_DEF  = 64;
    localparam int STRIDE       = 64;
    localparam int STRIDE_W     = 6;
    localparam int COLORS       = 7;
    localparam int STORE_DEPTH  = 2 * COLORS * STRIDE;
    localparam int ADDR_W       = 10;

    localparam int VAL_W  = 16;
    localparam int ACC_W  = 35;
    localparam int PROD_W = 48;

    // Scale factors as unsigned Q0.16.
    localparam logic [15:0] SCALE_REFL  = 16'd61604;
    localparam logic [15:0] SCALE_ILLUM = 16'd56653;
    localparam logic [15:0] OUT_MAX     = 16'hFFFF;

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_CONVERT = 1'b1;

    localparam logic [2:0] C_WHITE   = 3'd0;
    localparam logic [2:0] C_CYAN    = 3'd1;
    localparam logic [2:0] C_MAGENTA = 3'd2;
    localparam logic [2:0] C_YELLOW  = 3'd3;
    localparam logic [2:0] C_RED     = 3'd4;
    localparam logic [2:0] C_GREEN   = 3'd5;
    localparam logic [2:0] C_BLUE    = 3'd6;
    localparam logic [2:0] C_NONE    = 3'd7;

    localparam logic [1:0] TERM_MIN  = 2'd0;
    localparam logic [1:0] TERM_SEC  = 2'd1;
    localparam logic [1:0] TERM_PRI  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_MUL,
        S_ACC,
        S_SCALE,
        S_ROUND
    } t_state;

endpackage

// File: rtl/rts_if.sv
`timescale 1ns / 1ps

interface rts_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic        illum_set;
    logic [2:0]  basis_color;
    logic [5:0]  load_index;
    logic signed [15:0] basis_value;
    logic [15:0] red_in;
    logic [15:0] green_in;
    logic [15:0] blue_in;

    modport source (
        output valid, cmd, illum_set, basis_color, load_index, basis_value,
               red_in, green_in, blue_in,
        input  ready
    );
    modport sink (
        input  valid, cmd, illum_set, basis_color, load_index, basis_value,
               red_in, green_in, blue_in,
        output ready
    );
endinterface

interface rts_out_if;
    logic        valid;
    logic        ready;
    logic [5:0]  out_index;
    logic [15:0] out_value;
    logic        last;

    modport source (
        output valid, out_index, out_value, last,
        input  ready
    );
    modport sink (
        input  valid, out_index, out_value, last,
        output ready
    );
endinterface

// File: rtl/rgb_to_spectrum_smits.sv
`timescale 1ns / 1ps
// An accepted convert request runs each sample through S_READ, S_MUL and S_ACC for each
// of its three terms, then S_SCALE and S_ROUND, which loads the output register; a finished
// sample waits in S_ROUND while the output register is stalled, and no new request is taken
// until S_IDLE is reached again. Each sample makes three basis reads on one memory read port
// and four multiplies. Reset (synchronous, active low) clears the sequencer and the output
// valid flag only; the basis memory is not cleared and holds garbage until loaded.
module rgb_to_spectrum_smits
    import rts_pkg::*;
#(
    parameter int SAMPLES = SAMPLES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rts_in_if.sink    i_req,
    rts_out_if.source o_rsp
);

    localparam int IDX_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SAMPLES - 1);

    logic [VAL_W-1:0] r_mem [STORE_DEPTH];
    logic [VAL_W-1:0] r_mem_q;

    t_state r_state, n_state;

    logic              r_set;
    logic [VAL_W-1:0]  r_k0, r_k1, r_k2;
    logic [2:0]        r_col1, r_col2;
    logic [1:0]        r_term;
    logic [IDX_W-1:0]  r_sample;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [PROD_W-1:0] r_prod;
    logic              r_neg, r_big;

    logic              r_out_valid;
    logic [5:0]        r_out_index;
    logic [VAL_W-1:0]  r_out_value;
    logic              r_out_last;

    // Control from the sequencer.
    logic accept, wr_en, rd_en, scale_sel, slot_free, out_load;

    // Channel ordering on the incoming request.
    logic             red_le_grn, red_le_blu, grn_le_blu;
    logic [VAL_W-1:0] n_k0, n_k1, n_k2;
    logic [2:0]       n_col1, n_col2;

    always_comb begin
        red_le_grn = i_req.red_in <= i_req.green_in;
        red_le_blu = i_req.red_in <= i_req.blue_in;
        grn_le_blu = i_req.green_in <= i_req.blue_in;
        if (red_le_grn && red_le_blu) begin
            n_k0   = i_req.red_in;
            n_col1 = C_CYAN;
            if (grn_le_blu) begin
                n_k1 = i_req.green_in - i_req.red_in;
                n_col2 = C_BLUE;
                n_k2 = i_req.blue_in - i_req.green_in;
            end else begin
                n_k1 = i_req.blue_in - i_req.red_in;
                n_col2 = C_GREEN;
                n_k2 = i_req.green_in - i_req.blue_in;
            end
        end else if (grn_le_blu) begin
            n_k0   = i_req.green_in;
            n_col1 = C_MAGENTA;
            if (red_le_blu) begin
                n_k1 = i_req.red_in - i_req.green_in;
                n_col2 = C_BLUE;
                n_k2 = i_req.blue_in - i_req.red_in;
            end else begin
                n_k1 = i_req.blue_in - i_req.green_in;
                n_col2 = C_RED;
                n_k2 = i_req.red_in - i_req.blue_in;
            end
        end else begin
            n_k0   = i_req.blue_in;
            n_col1 = C_YELLOW;
            if (red_le_grn) begin
                n_k1 = i_req.red_in - i_req.blue_in;
                n_col2 = C_GREEN;
                n_k2 = i_req.green_in - i_req.red_in;
            end else begin
                n_k1 = i_req.green_in - i_req.blue_in;
                n_col2 = C_RED;
                n_k2 = i_req.red_in - i_req.green_in;
            end
        end
    end

    // Basis address: (set * 7 + color) * 64 + sample.
    logic [2:0]        term_col;
    logic [3:0]        wr_row, rd_row;
    logic [ADDR_W-1:0] wr_addr, rd_addr;

    always_comb begin
        case (r_term)
            TERM_MIN: term_col = C_WHITE;
            TERM_SEC: term_col = r_col1;
            TERM_PRI: term_col = r_col2;
            default:  term_col = C_WHITE;
        endcase
        wr_row  = i_req.illum_set ? 4'(i_req.basis_color) + 4'(COLORS)
                                  : 4'(i_req.basis_color);
        rd_row  = r_set ? 4'(term_col) + 4'(COLORS) : 4'(term_col);
        wr_addr = {wr_row, i_req.load_index};
        rd_addr = {rd_row, STRIDE_W'(r_sample)};
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= i_req.basis_value;
        end
        if (rd_en) begin
            r_mem_q <= r_mem[rd_addr];
        end
    end

    // Shared multiplier: term products in S_MUL, scaling in S_SCALE.
    logic [VAL_W-1:0]         term_k;
    logic signed [31:0]       mul_a;
    logic signed [16:0]       mul_b;
    logic signed [PROD_W-1:0] mul_p;

    always_comb begin
        case (r_term)
            TERM_MIN: term_k = r_k0;
            TERM_SEC: term_k = r_k1;
            TERM_PRI: term_k = r_k2;
            default:  term_k = r_k0;
        endcase
        if (scale_sel) begin
            mul_a = {1'b0, r_acc[30:0]};
            mul_b = {1'b0, (r_set ? SCALE_ILLUM : SCALE_REFL)};
        end else begin
            mul_a = {16'd0, term_k};
            mul_b = {r_mem_q[VAL_W-1], r_mem_q};
        end
        mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // Rounding half up from Q.42 to Q4.12.
    logic [PROD_W-1:0] rnd;
    logic [16:0]       v17;
    logic [VAL_W-1:0]  v_out;

    always_comb begin
        rnd = r_prod + PROD_W'(64'd1 << 29);
        v17 = rnd[46:30];
        if (r_neg) begin
            v_out = '0;
        end else if (r_big || v17[16]) begin
            v_out = OUT_MAX;
        end else begin
            v_out = v17[15:0];
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_req.valid && i_req.cmd == CMD_CONVERT) n_state = S_READ;
            end
            S_READ:  n_state = S_MUL;
            S_MUL:   n_state = S_ACC;
            S_ACC:   n_state = (r_term == TERM_PRI) ? S_SCALE : S_READ;
            S_SCALE: n_state = S_ROUND;
            S_ROUND: begin
                if (slot_free) n_state = (r_sample == LAST_IDX) ? S_IDLE : S_READ;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        slot_free = !r_out_valid || o_rsp.ready;
        accept    = 1'b0;
        wr_en     = 1'b0;
        rd_en     = 1'b0;
        scale_sel = 1'b0;
        out_load  = 1'b0;
        case (r_state)
            S_IDLE: begin
                accept = i_req.valid;
                wr_en  = i_req.valid && i_req.cmd == CMD_LOAD
                      && i_req.basis_color != C_NONE
                      && 7'(i_req.load_index) < 7'(SAMPLES);
            end
            S_READ:  rd_en     = 1'b1;
            S_SCALE: scale_sel = 1'b1;
            S_ROUND: out_load  = slot_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_term      <= TERM_MIN;
            r_sample    <= '0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            if (accept) begin
                r_term   <= TERM_MIN;
                r_sample <= '0;
            end else if (r_state == S_ACC) begin
                r_term <= (r_term == TERM_PRI) ? TERM_MIN : r_term + 2'd1;
            end else if (out_load) begin
                r_sample <= r_sample + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_req.cmd == CMD_CONVERT) begin
            r_set  <= i_req.illum_set;
            r_k0   <= n_k0;
            r_k1   <= n_k1;
            r_k2   <= n_k2;
            r_col1 <= n_col1;
            r_col2 <= n_col2;
        end
        if (r_state == S_MUL || scale_sel) begin
            r_prod <= mul_p;
        end
        if (r_state == S_ACC) begin
            if (r_term == TERM_MIN) begin
                r_acc <= r_prod[ACC_W-1:0];
            end else begin
                r_acc <= r_acc + r_prod[ACC_W-1:0];
            end
        end
        if (scale_sel) begin
            r_neg <= r_acc[ACC_W-1] || r_acc == '0;
            r_big <= !r_acc[ACC_W-1] && r_acc[ACC_W-2:31] != '0;
        end
        if (out_load) begin
            r_out_index <= 6'(r_sample);
            r_out_value <= v_out;
            r_out_last  <= r_sample == LAST_IDX;
        end
    end

    assign i_req.ready     = r_state == S_IDLE;
    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.out_index = r_out_index;
    assign o_rsp.out_value = r_out_value;
    assign o_rsp.last      = r_out_last;

`ifndef SYNTHESIS
    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> !i_req.ready)
        else $error("request taken while a conversion is running");

    a_convert_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready && i_req.cmd == CMD_CONVERT |=> r_state == S_READ)
        else $error("convert request did not start the sequencer");

    a_result_posted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_ROUND && slot_free |=> o_rsp.valid)
        else $error("finished sample not presented");

    a_term_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCALE |-> $past(r_term) == TERM_PRI)
        else $error("scaling began before all three terms were summed");
`endif

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps

import rts_pkg::*;

typedef struct packed {
    logic        cmd;
    logic        illum_set;
    logic [2:0]  basis_color;
    logic [5:0]  load_index;
    logic [15:0] basis_value;
    logic [15:0] red_in;
    logic [15:0] green_in;
    logic [15:0] blue_in;
} spec_req_t;

typedef struct packed {
    logic [5:0]  out_index;
    logic [15:0] out_value;
    logic        last;
} spec_sample_t;

class spectrum_scoreboard;
    logic [15:0]  basis_tab [0:1][0:COLORS-1][0:STRIDE-1];
    spec_sample_t spectrum_q[$];
    int           n_samples;
    int           errors;

    function new(int samples);
        n_samples = samples;
        errors    = 0;
        foreach (basis_tab[s, c, i]) basis_tab[s][c][i] = '0;
    endfunction

    function longint basis_at(logic set, logic [2:0] color, int idx);
        return longint'($signed(basis_tab[set][color][idx]));
    endfunction

    // Loads update the private copy of the basis table; converts queue one
    // expected sample per spectral index.
    function void note_request(spec_req_t r);
        longint       rv, gv, bv, k0, k1, k2, acc, scaled, scale;
        logic [2:0]   c1, c2;
        spec_sample_t e;
        if (r.cmd == CMD_LOAD) begin
            if (r.basis_color != C_NONE && int'(r.load_index) < n_samples) begin
                basis_tab[r.illum_set][r.basis_color][r.load_index] = r.basis_value;
            end
            return;
        end
        rv = longint'(r.red_in);
        gv = longint'(r.green_in);
        bv = longint'(r.blue_in);
        if (rv <= gv && rv <= bv) begin
            k0 = rv;
            c1 = C_CYAN;
            if (gv <= bv) begin
                k1 = gv - rv; c2 = C_BLUE;  k2 = bv - gv;
            end else begin
                k1 = bv - rv; c2 = C_GREEN; k2 = gv - bv;
            end
        end else if (gv <= bv) begin
            k0 = gv;
            c1 = C_MAGENTA;
            // With red above blue the red term takes red minus blue.
            if (rv <= bv) begin
                k1 = rv - gv; c2 = C_BLUE; k2 = bv - rv;
            end else begin
                k1 = bv - gv; c2 = C_RED;  k2 = rv - bv;
            end
        end else begin
            k0 = bv;
            c1 = C_YELLOW;
            if (rv <= gv) begin
                k1 = rv - bv; c2 = C_GREEN; k2 = gv - rv;
            end else begin
                k1 = gv - bv; c2 = C_RED;   k2 = rv - gv;
            end
        end
        scale = r.illum_set ? longint'(SCALE_ILLUM) : longint'(SCALE_REFL);
        for (int i = 0; i < n_samples; i++) begin
            acc = k0 * basis_at(r.illum_set, C_WHITE, i)
                + k1 * basis_at(r.illum_set, c1, i)
                + k2 * basis_at(r.illum_set, c2, i);
            scaled = 0;
            if (acc > 0) begin
                scaled = (acc * scale + (64'sd1 << 29)) >>> 30;
                if (scaled > longint'(OUT_MAX)) scaled = longint'(OUT_MAX);
            end
            e.out_index = 6'(i);
            e.out_value = scaled[15:0];
            e.last      = (i == n_samples - 1);
            spectrum_q.push_back(e);
        end
    endfunction

    function void check_result(logic [5:0] idx, logic [15:0] val, logic last);
        spec_sample_t e;
        if (spectrum_q.size() == 0) begin
            $error("unexpected sample: out_index=%0d out_value=%0d last=%0d",
                   idx, val, last);
            errors++;
            return;
        end
        e = spectrum_q.pop_front();
        if (idx !== e.out_index) begin
            $error("out_index: expected %0d, actual %0d", e.out_index, idx);
            errors++;
        end
        if (val !== e.out_value) begin
            $error("out_value: expected %0d, actual %0d", e.out_value, val);
            errors++;
        end
        if (last !== e.last) begin
            $error("last: expected %0d, actual %0d", e.last, last);
            errors++;
        end
    endfunction

    function int pending();
        return spectrum_q.size();
    endfunction
endclass

module tb;

    localparam int N_SAMPLES    = SAMPLES_DEF;
    localparam int PRELOAD      = 2 * COLORS * N_SAMPLES;
    localparam int DIRECTED     = 22;
    localparam int RANDOM_ITEMS = 270;
    localparam int MAX_GAP      = 40;
    localparam int MAX_STALL    = 15;
    localparam int CONVERT_CYC  = 11 * N_SAMPLES + 1;
    localparam longint WORST_ITEM = CONVERT_CYC + N_SAMPLES * (MAX_STALL + 1) + MAX_GAP + 16;
    localparam longint CYCLE_LIMIT = 4 * (PRELOAD + DIRECTED + RANDOM_ITEMS) * WORST_ITEM;

    // Red, green, blue of the directed converts.
    localparam logic [47:0] DIR_RGB [0:15] = '{
        {16'd0,     16'd0,     16'd0},
        {16'd65535, 16'd65535, 16'd65535},
        {16'd100,   16'd200,   16'd300},
        {16'd100,   16'd300,   16'd200},
        {16'd200,   16'd100,   16'd300},
        {16'd300,   16'd100,   16'd200},
        {16'd200,   16'd300,   16'd100},
        {16'd300,   16'd200,   16'd100},
        {16'd500,   16'd500,   16'd500},
        {16'd500,   16'd500,   16'd900},
        {16'd500,   16'd900,   16'd500},
        {16'd900,   16'd500,   16'd500},
        {16'd900,   16'd900,   16'd500},
        {16'd65535, 16'd0,     16'd65535},
        {16'd0,     16'd65535, 16'd0},
        {16'd65535, 16'd0,     16'd1}
    };

    typedef enum int {RX_STEADY, RX_COIN, RX_RUNS} rx_mode_t;

    logic clk;
    logic rst_n;
    int   burst_left;
    longint cycles;

    spectrum_scoreboard sb;

    rts_in_if  req_if ();
    rts_out_if rsp_if ();

    rgb_to_spectrum_smits #(.SAMPLES(N_SAMPLES)) uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [15:0] rand_channel();
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(0, 255));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_basis();
        case ($urandom_range(0, 7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic spec_req_t make_load(logic set, logic [2:0] color, logic [5:0] idx,
                                            logic [15:0] value);
        spec_req_t r;
        r.cmd         = CMD_LOAD;
        r.illum_set   = set;
        r.basis_color = color;
        r.load_index  = idx;
        r.basis_value = value;
        r.red_in      = 16'($urandom);
        r.green_in    = 16'($urandom);
        r.blue_in     = 16'($urandom);
        return r;
    endfunction

    function automatic spec_req_t make_convert(logic set, logic [15:0] red, logic [15:0] green,
                                               logic [15:0] blue);
        spec_req_t r;
        r.cmd         = CMD_CONVERT;
        r.illum_set   = set;
        r.basis_color = 3'($urandom);
        r.load_index  = 6'($urandom);
        r.basis_value = 16'($urandom);
        r.red_in      = red;
        r.green_in    = green;
        r.blue_in     = blue;
        return r;
    endfunction

    // Presents one request, waits for it to be taken and, at the end of a
    // burst, may leave the channel idle for a random gap.
    task automatic issue(input spec_req_t r);
        int gap;
        @(negedge clk);
        req_if.cmd         = r.cmd;
        req_if.illum_set   = r.illum_set;
        req_if.basis_color = r.basis_color;
        req_if.load_index  = r.load_index;
        req_if.basis_value = r.basis_value;
        req_if.red_in      = r.red_in;
        req_if.green_in    = r.green_in;
        req_if.blue_in     = r.blue_in;
        req_if.valid       = 1'b1;
        do @(posedge clk); while (req_if.ready !== 1'b1);
        sb.note_request(r);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            case ($urandom_range(0, 5))
                0, 1:    gap = 0;
                2, 3, 4: gap = $urandom_range(1, 8);
                default: gap = $urandom_range(9, MAX_GAP);
            endcase
            if (gap > 0) begin
                @(negedge clk);
                req_if.valid = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
    endtask

    // Output back-pressure: segments of always-ready, coin-flip, and long
    // alternating stall runs.
    initial begin
        rx_mode_t mode;
        int       seg;
        int       run;
        logic     lvl;
        rsp_if.ready = 1'b1;
        lvl = 1'b1;
        run = 0;
        forever begin
            mode = rx_mode_t'($urandom_range(0, 2));
            seg  = $urandom_range(20, 400);
            repeat (seg) begin
                @(negedge clk);
                case (mode)
                    RX_STEADY: rsp_if.ready = 1'b1;
                    RX_COIN:   rsp_if.ready = 1'($urandom_range(0, 1));
                    default: begin
                        if (run <= 0) begin
                            lvl = ~lvl;
                            run = lvl ? $urandom_range(1, 10) : $urandom_range(1, MAX_STALL);
                        end
                        rsp_if.ready = lvl;
                        run--;
                    end
                endcase
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            sb.check_result(rsp_if.out_index, rsp_if.out_value, rsp_if.last);
        end
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    initial begin
        logic [15:0] rr, gg, bb;
        sb = new(N_SAMPLES);
        burst_left = 1;
        rst_n              = 1'b0;
        req_if.valid       = 1'b0;
        req_if.cmd         = CMD_LOAD;
        req_if.illum_set   = 1'b0;
        req_if.basis_color = C_WHITE;
        req_if.load_index  = '0;
        req_if.basis_value = '0;
        req_if.red_in      = '0;
        req_if.green_in    = '0;
        req_if.blue_in     = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Every entry of both sets is written before any convert reads it.
        for (int s = 0; s < 2; s++) begin
            for (int c = 0; c < COLORS; c++) begin
                for (int i = 0; i < N_SAMPLES; i++) begin
                    issue(make_load(1'(s), 3'(c), 6'(i), rand_basis()));
                end
            end
        end

        issue(make_load(1'b0, C_WHITE, 6'd0, 16'h7FFF));
        issue(make_load(1'b0, C_WHITE, 6'(N_SAMPLES - 1), 16'h8000));
        issue(make_load(1'b1, C_BLUE, 6'd0, 16'h8000));
        issue(make_load(1'b1, C_BLUE, 6'(N_SAMPLES - 1), 16'h7FFF));
        // Color seven does not name a basis spectrum and must be dropped.
        issue(make_load(1'b0, C_NONE, 6'd5, 16'h1234));
        issue(make_load(1'b1, C_NONE, 6'd63, 16'hFFFF));
        for (int j = 0; j < 16; j++) begin
            issue(make_convert(1'(j), DIR_RGB[j][47:32], DIR_RGB[j][31:16], DIR_RGB[j][15:0]));
        end

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if ($urandom_range(0, 1) == 0) begin
                issue(make_load(1'($urandom), 3'($urandom), 6'($urandom), rand_basis()));
            end else begin
                rr = rand_channel();
                gg = rand_channel();
                bb = rand_channel();
                case ($urandom_range(0, 5))
                    0:       gg = rr;
                    1:       bb = gg;
                    2:       bb = rr;
                    default: ;
                endcase
                issue(make_convert(1'($urandom), rr, gg, bb));
            end
        end
        @(negedge clk);
        req_if.valid = 1'b0;

        while (sb.pending() != 0) @(posedge clk);
        repeat (CONVERT_CYC + 16) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
